// ===== hw/rtl/tnrf_pkg.sv =====
// shared types and constants of the telnet receive filter
`default_nettype none

package tnrf_pkg;

  // telnet byte codes
  localparam logic [7:0] BYTE_IAC     = 8'd255;
  localparam logic [7:0] BYTE_DONT    = 8'd254;
  localparam logic [7:0] BYTE_DO      = 8'd253;
  localparam logic [7:0] BYTE_SB      = 8'd250;
  localparam logic [7:0] BYTE_SE      = 8'd240;
  localparam logic [7:0] BYTE_CMD_LO  = 8'd236;
  localparam logic [7:0] BYTE_NUL     = 8'd0;

  // option codes
  localparam logic [7:0] OPT_SGA      = 8'd3;
  localparam logic [7:0] OPT_EOR      = 8'd25;
  localparam logic [7:0] OPT_NAWS     = 8'd31;
  localparam logic [7:0] OPT_MXP      = 8'd91;
  localparam logic [7:0] OPT_GMCP     = 8'd201;

  // option flag bit positions
  localparam int FLAG_EOR  = 0;
  localparam int FLAG_GMCP = 1;
  localparam int FLAG_MXP  = 2;
  localparam int FLAG_GA   = 3;

  localparam logic [2:0]  NAWS_BYTES    = 3'd4;
  localparam logic [15:0] SEQ_LEN_MAX   = 16'hFFFF;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  // parser states, one-hot
  typedef enum logic [5:0] {
    ST_DATA   = 6'b000001,
    ST_IAC    = 6'b000010,
    ST_OPT    = 6'b000100,
    ST_SBOPT  = 6'b001000,
    ST_SBBODY = 6'b010000,
    ST_SBIAC  = 6'b100000
  } parser_state_t;

  // parser context carried from byte to byte
  typedef struct packed {
    parser_state_t pst;
    logic [7:0]    command_byte;
    logic [7:0]    sub_option;
    logic [2:0]    naws_index;
    logic [15:0]   cols;
    logic [15:0]   rows;
    logic [3:0]    flags;
    logic [15:0]   seq_length;
  } parser_ctx_t;

  // one result item
  typedef struct packed {
    logic        overflow;
    logic [3:0]  option_flags;
    logic [15:0] window_rows;
    logic [15:0] window_cols;
    logic        size_update;
    logic [7:0]  data_byte;
    logic        data_valid;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/telnet_receive_filter.sv =====
// top level of the telnet receive filter: input register, parser, result register
// a request accepted into the input register passes the parser step into the result register, which drives m_tdata
// throughput: one byte per cycle while no result is held, set by the single parser step between registers
// a full result register stalls the input register, which then holds one request
// reset (synchronous, rst high): parser in data state, all context zero,
// max_sequence_len 4096, no request or result held
`default_nettype none

module telnet_receive_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [0] data_valid, [8:1] data_byte, [9] size_update,
                                      // [25:10] window_cols, [41:26] window_rows,
                                      // [45:42] option_flags, [46] overflow, [47] zero
  // max_sequence_len write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import tnrf_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic [15:0] max_len;
  parser_ctx_t ctx;
  parser_ctx_t ctx_next;
  result_t     res_next;
  result_t     res;
  logic        advance;

  // handshake control
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_len <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // parser step
  tnrf_step u_step (
    .cur     (ctx),
    .rx_byte (in_byte),
    .max_len (max_len),
    .nxt     (ctx_next),
    .res     (res_next)
  );

  // parser context
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '{pst: ST_DATA, command_byte: 8'h00, sub_option: 8'h00, naws_index: 3'd0,
               cols: 16'h0000, rows: 16'h0000, flags: 4'h0, seq_length: 16'h0000};
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {1'b0, res};

  // overflow always returns the parser to data state
  a_ovf_to_data: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.overflow |=> ctx.pst == ST_DATA)
    else $error("parser not in data state after overflow");

  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a held result");

  // a delivered data byte is never NUL
  a_no_nul: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.data_valid |-> res.data_byte != BYTE_NUL)
    else $error("NUL byte delivered as data");

  // register write lands
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> max_len == $past(cfg_data))
    else $error("max_sequence_len write lost");

endmodule

`default_nettype wire

// ===== hw/rtl/tnrf_step.sv =====
// next-context and result logic for one received byte
`default_nettype none

module tnrf_step (
  input  wire tnrf_pkg::parser_ctx_t cur,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [15:0]           max_len,
  output tnrf_pkg::parser_ctx_t      nxt,
  output tnrf_pkg::result_t          res
);
  import tnrf_pkg::*;

  logic        active;
  logic [15:0] len;
  logic        body_en;
  logic [7:0]  body_val;

  // pending sequence length including this byte
  always_comb begin
    active = (cur.pst != ST_DATA) || (rx_byte == BYTE_IAC);
    if (cur.pst == ST_DATA) begin
      len = 16'd1;
    end else if (cur.seq_length == SEQ_LEN_MAX) begin
      len = SEQ_LEN_MAX;
    end else begin
      len = cur.seq_length + 16'd1;
    end
  end

  // parser transition
  always_comb begin
    nxt      = cur;
    res      = '0;
    body_en  = 1'b0;
    body_val = rx_byte;
    if (active && (len > max_len)) begin
      res.overflow   = 1'b1;
      nxt.pst        = ST_DATA;
      nxt.seq_length = '0;
    end else begin
      if (active) begin
        nxt.seq_length = len;
      end
      unique case (cur.pst)
        ST_DATA: begin
          if (rx_byte == BYTE_IAC) begin
            nxt.pst = ST_IAC;
          end else if (rx_byte != BYTE_NUL) begin
            res.data_valid = 1'b1;
            res.data_byte  = rx_byte;
          end
        end
        ST_IAC: begin
          if (rx_byte == BYTE_IAC) begin
            res.data_valid = 1'b1;
            res.data_byte  = BYTE_IAC;
            nxt.pst        = ST_DATA;
          end else if (rx_byte > BYTE_SB) begin
            nxt.command_byte = rx_byte;
            nxt.pst          = ST_OPT;
          end else if (rx_byte == BYTE_SB) begin
            nxt.pst = ST_SBOPT;
          end else begin
            // a byte below the command range is handled as data
            if ((rx_byte < BYTE_CMD_LO) && (rx_byte != BYTE_NUL)) begin
              res.data_valid = 1'b1;
              res.data_byte  = rx_byte;
            end
            nxt.pst = ST_DATA;
          end
        end
        ST_OPT: begin
          if (cur.command_byte == BYTE_DO) begin
            if (rx_byte == OPT_EOR) begin
              nxt.flags[FLAG_EOR] = 1'b1;
            end else if (rx_byte == OPT_GMCP) begin
              nxt.flags[FLAG_GMCP] = 1'b1;
            end else if (rx_byte == OPT_MXP) begin
              nxt.flags[FLAG_MXP] = 1'b1;
            end
          end else if ((cur.command_byte == BYTE_DONT) && (rx_byte == OPT_SGA)) begin
            nxt.flags[FLAG_GA] = 1'b1;
          end
          nxt.pst = ST_DATA;
        end
        ST_SBOPT: begin
          nxt.sub_option = rx_byte;
          nxt.naws_index = '0;
          if (rx_byte == OPT_NAWS) begin
            nxt.cols = '0;
            nxt.rows = '0;
          end
          nxt.pst = ST_SBBODY;
        end
        ST_SBBODY: begin
          if (rx_byte == BYTE_IAC) begin
            nxt.pst = ST_SBIAC;
          end else begin
            body_en = 1'b1;
          end
        end
        ST_SBIAC: begin
          if (rx_byte == BYTE_SE) begin
            res.size_update = (cur.sub_option == OPT_NAWS);
            nxt.pst         = ST_DATA;
          end else begin
            // escaped body byte
            body_en  = 1'b1;
            body_val = BYTE_IAC;
            nxt.pst  = ST_SBBODY;
          end
        end
        default: begin
          nxt.pst = ST_DATA;
        end
      endcase

      // naws body decode
      if (body_en && (cur.sub_option == OPT_NAWS) && (cur.naws_index < NAWS_BYTES)) begin
        case (cur.naws_index[1:0])
          2'd0:    nxt.cols = {body_val, 8'h00};
          2'd1:    nxt.cols = {cur.cols[15:8], cur.cols[7:0] | body_val};
          2'd2:    nxt.rows = {body_val, 8'h00};
          default: nxt.rows = {cur.rows[15:8], cur.rows[7:0] | body_val};
        endcase
        nxt.naws_index = cur.naws_index + 3'd1;
      end

      if (nxt.pst == ST_DATA) begin
        nxt.seq_length = '0;
      end
    end
    res.window_cols  = nxt.cols;
    res.window_rows  = nxt.rows;
    res.option_flags = nxt.flags;
  end

endmodule

`default_nettype wire
